### src/leg_joint_to_servo_pwm_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the leg joint to servo PWM mapper
// Clocked on clk, disabled while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LEG_JOINT_TO_SERVO_PWM_ASSERT_SVH
`define LEG_JOINT_TO_SERVO_PWM_ASSERT_SVH
`ifndef SYNTHESIS
`define LJ2S_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lj2s check failed");
`define LJ2S_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lj2s check failed");
`else
`define LJ2S_ASSERT_IMP(lbl, ante, cons)
`define LJ2S_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/lj2s_pkg.sv
// ----------------------------------------------------------------------------
// lj2s_pkg
// Types and constants shared by the leg joint to servo PWM mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package lj2s_pkg;

	localparam int ANG_W = 18;

	// angles in degrees, 8 fraction bits
	localparam logic signed [19:0] DEG90  = 20'sd23040;
	localparam logic signed [26:0] DEG180 = 27'sd46080;

	// curve coefficients with 24 fraction bits
	localparam logic [16:0] CURVE_A = 17'd111552;
	localparam logic [22:0] CURVE_B = 23'd7405463;
	// constant term at 40 fraction bits plus the rounding half
	localparam logic [57:0] CURVE_K = (58'd92778004 << 16) + (58'd1 << 31);

	// duty mapping: 102 + floor(d * 409 / 46080), 46080 = 1024 * 45
	localparam logic [8:0]  DUTY_SPAN = 9'd409;
	localparam logic [12:0] DUTY_MIN  = 13'd102;
	localparam logic [12:0] DUTY_MAX  = 13'd511;
	localparam logic [22:0] RECIP45   = 23'd5965233;

	typedef enum logic [1:0] {
		BEAT_HIP   = 2'd0,
		BEAT_THIGH = 2'd1,
		BEAT_SHANK = 2'd2
	} beat_t;

	typedef struct packed {
		logic [1:0]              leg;
		logic                    ik_mode;
		logic signed [ANG_W-1:0] rest_hip;
		logic signed [ANG_W-1:0] rest_thigh;
		logic signed [ANG_W-1:0] rest_shank;
		logic signed [ANG_W-1:0] hip_offset;
		logic signed [ANG_W-1:0] thigh_angle;
		logic signed [ANG_W-1:0] shank_angle;
		logic signed [ANG_W-1:0] shank_trim;
		logic signed [ANG_W-1:0] crawl_comp;
	} item_t;

	typedef struct packed {
		logic [3:0] lch;
		logic       board;
		logic [2:0] bch;
		logic       last;
	} side_t;

endpackage

`default_nettype wire

### src/lj2s_if.sv
// ----------------------------------------------------------------------------
// lj2s channel interfaces
// Joint input, configuration write and servo result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lj2s_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              leg;
	logic                                    ik_mode;
	logic signed [lj2s_pkg::ANG_W-1:0]       rest_hip;
	logic signed [lj2s_pkg::ANG_W-1:0]       rest_thigh;
	logic signed [lj2s_pkg::ANG_W-1:0]       rest_shank;
	logic signed [lj2s_pkg::ANG_W-1:0]       hip_offset;
	logic signed [lj2s_pkg::ANG_W-1:0]       thigh_angle;
	logic signed [lj2s_pkg::ANG_W-1:0]       shank_angle;
	logic signed [lj2s_pkg::ANG_W-1:0]       shank_trim;
	logic signed [lj2s_pkg::ANG_W-1:0]       crawl_comp;
	modport source(output valid, leg, ik_mode, rest_hip, rest_thigh, rest_shank, hip_offset,
		thigh_angle, shank_angle, shank_trim, crawl_comp, input ready);
	modport sink(input valid, leg, ik_mode, rest_hip, rest_thigh, rest_shank, hip_offset,
		thigh_angle, shank_angle, shank_trim, crawl_comp, output ready);
endinterface

interface lj2s_cfg_if;
	logic                              valid;
	logic                              ready;
	logic signed [lj2s_pkg::ANG_W-1:0] curve_bias;
	modport source(output valid, curve_bias, input ready);
	modport sink(input valid, curve_bias, output ready);
endinterface

interface lj2s_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  logical_channel;
	logic        board_select;
	logic [2:0]  board_channel;
	logic [12:0] on_count;
	logic [12:0] off_count;
	logic        last_of_leg;
	modport source(output valid, logical_channel, board_select, board_channel, on_count,
		off_count, last_of_leg, input ready);
	modport sink(input valid, logical_channel, board_select, board_channel, on_count,
		off_count, last_of_leg, output ready);
endinterface

`default_nettype wire

### src/leg_joint_to_servo_pwm.sv
// ----------------------------------------------------------------------------
// leg_joint_to_servo_pwm
// Maps one leg's joint angles to hip, thigh and shank servo PWM counts.
// ----------------------------------------------------------------------------
// The input register issues the three beats of an item (hip, thigh, shank) into an
// 8-stage pipeline and can accept the next item as the shank beat issues; one result
// per cycle leaves while servo.ready does not stall the output.
// Reset clears all valid bits and sets the curve bias to zero.
`default_nettype none

`include "leg_joint_to_servo_pwm_assert.svh"

module leg_joint_to_servo_pwm (
	input  wire logic clk,
	input  wire logic arst_n,
	lj2s_in_if.sink   joint,
	lj2s_cfg_if.sink  cfg,
	lj2s_out_if.source servo
);

	logic                       en;
	logic signed [17:0]         bias_q;
	logic                       hold_vld_q;
	lj2s_pkg::beat_t            cnt_q;
	lj2s_pkg::item_t            item_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	lj2s_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [19:0] t_s1, base_s1, base_s2, base_s3, base_s4;
	logic curve_s1, curve_s2, curve_s3, curve_s4;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic signed [25:0] c_s4;
	logic [15:0] d_s5;
	logic [8:0]  q_s7;
	logic [12:0] off_s8;

	logic               left, rear;
	logic signed [19:0] base;
	logic signed [26:0] ang;
	lj2s_pkg::side_t    side;

	// advance whenever the output register is free or being taken
	assign en = !vld_s8 || servo.ready;
	assign joint.ready = !hold_vld_q || (en && cnt_q == lj2s_pkg::BEAT_SHANK);
	assign cfg.ready = 1'b1;

	// write the bias register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (cfg.valid) begin
			bias_q <= cfg.curve_bias;
		end
	end

	// hold the item and count its three beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			cnt_q      <= lj2s_pkg::BEAT_HIP;
		end else if (joint.valid && joint.ready) begin
			hold_vld_q <= 1'b1;
			cnt_q      <= lj2s_pkg::BEAT_HIP;
		end else if (en && hold_vld_q) begin
			case (cnt_q)
				lj2s_pkg::BEAT_HIP: begin
					cnt_q <= lj2s_pkg::BEAT_THIGH;
				end
				lj2s_pkg::BEAT_THIGH: begin
					cnt_q <= lj2s_pkg::BEAT_SHANK;
				end
				default: begin
					hold_vld_q <= 1'b0;
					cnt_q      <= lj2s_pkg::BEAT_HIP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (joint.valid && joint.ready) begin
			item_q <= '{leg: joint.leg, ik_mode: joint.ik_mode, rest_hip: joint.rest_hip,
				rest_thigh: joint.rest_thigh, rest_shank: joint.rest_shank,
				hip_offset: joint.hip_offset, thigh_angle: joint.thigh_angle,
				shank_angle: joint.shank_angle, shank_trim: joint.shank_trim,
				crawl_comp: joint.crawl_comp};
		end
	end

	// stage 1: channel numbers and the angle without the curve
	assign left = item_q.leg == 2'd0 || item_q.leg == 2'd3;
	assign rear = item_q.leg[1];

	always_comb begin
		side.board = !left;
		side.bch   = (rear ? 3'd3 : 3'd0) + 3'(cnt_q);
		side.lch   = (left ? 4'd0 : 4'd6) + (rear ? 4'd3 : 4'd0) + 4'(cnt_q);
		side.last  = cnt_q == lj2s_pkg::BEAT_SHANK;
		case (cnt_q)
			lj2s_pkg::BEAT_HIP: begin
				base = 20'(item_q.rest_hip) + 20'(item_q.hip_offset);
			end
			lj2s_pkg::BEAT_THIGH: begin
				if (!item_q.ik_mode) begin
					base = 20'(item_q.rest_thigh);
				end else if (left) begin
					base = 20'(item_q.rest_thigh) + lj2s_pkg::DEG90 - 20'(item_q.thigh_angle);
				end else begin
					base = 20'(item_q.rest_thigh) - lj2s_pkg::DEG90 + 20'(item_q.thigh_angle);
				end
			end
			default: begin
				if (!item_q.ik_mode) begin
					base = 20'(item_q.rest_shank);
				end else if (left) begin
					base = 20'(item_q.rest_shank) - lj2s_pkg::DEG90 + 20'(item_q.crawl_comp);
				end else begin
					base = 20'(item_q.rest_shank) + lj2s_pkg::DEG90 + 20'(item_q.crawl_comp);
				end
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
		end else if (en) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <=
				{hold_vld_q, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7};
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= 20'(item_q.shank_angle) + 20'(bias_q) + 20'(item_q.shank_trim);
			base_s1  <= base;
			curve_s1 <= item_q.ik_mode && cnt_q == lj2s_pkg::BEAT_SHANK;
			neg_s1   <= !left;
			side_s1  <= side;
			base_s2  <= base_s1;
			curve_s2 <= curve_s1;
			neg_s2   <= neg_s1;
			side_s2  <= side_s1;
			base_s3  <= base_s2;
			curve_s3 <= curve_s2;
			neg_s3   <= neg_s2;
			side_s3  <= side_s2;
			base_s4  <= base_s3;
			curve_s4 <= curve_s3;
			neg_s4   <= neg_s3;
			side_s4  <= side_s3;
			side_s5  <= side_s4;
			side_s6  <= side_s5;
			side_s7  <= side_s6;
			side_s8  <= side_s7;
			off_s8   <= lj2s_pkg::DUTY_MIN + 13'(q_s7);
		end
	end

	lj2s_curve u_curve (
		.clk  (clk),
		.en   (en),
		.t_s1 (t_s1),
		.c_s4 (c_s4)
	);

	// stage 5: apply the curve and clamp to 0..180 degrees
	always_comb begin
		ang = 27'(base_s4);
		if (curve_s4) begin
			ang = neg_s4 ? ang - 27'(c_s4) : ang + 27'(c_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ang < 27'sd0) begin
				d_s5 <= '0;
			end else if (ang > lj2s_pkg::DEG180) begin
				d_s5 <= lj2s_pkg::DEG180[15:0];
			end else begin
				d_s5 <= ang[15:0];
			end
		end
	end

	lj2s_duty u_duty (
		.clk  (clk),
		.en   (en),
		.d_s5 (d_s5),
		.q_s7 (q_s7)
	);

	// drive the result channel
	assign servo.valid           = vld_s8;
	assign servo.logical_channel = side_s8.lch;
	assign servo.board_select    = side_s8.board;
	assign servo.board_channel   = side_s8.bch;
	assign servo.on_count        = '0;
	assign servo.off_count       = off_s8;
	assign servo.last_of_leg     = side_s8.last;

	`LJ2S_ASSERT_IMP(a_ready_on_last, hold_vld_q && joint.ready, en && cnt_q == lj2s_pkg::BEAT_SHANK)
	`LJ2S_ASSERT_NXT(a_accept_loads, joint.valid && joint.ready, hold_vld_q && cnt_q == lj2s_pkg::BEAT_HIP)
	`LJ2S_ASSERT_IMP(a_duty_range, vld_s8, off_s8 >= lj2s_pkg::DUTY_MIN && off_s8 <= lj2s_pkg::DUTY_MAX)
	`LJ2S_ASSERT_NXT(a_stall_holds, vld_s8 && !servo.ready, vld_s8 && $stable(off_s8) && $stable(side_s8))

endmodule

`default_nettype wire

### src/lj2s_curve.sv
// ----------------------------------------------------------------------------
// lj2s_curve
// Three-stage shank curve a*t*t + b*t + c, rounded to 8 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lj2s_curve (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [19:0] t_s1,
	output logic signed [25:0]      c_s4
);

	logic signed [39:0] tt;
	logic signed [43:0] bt;
	logic [37:0]        tt_s2;
	logic signed [43:0] bt_s2;
	logic [35:0]        ph_s3;
	logic [35:0]        pl_s3;
	logic signed [43:0] bt_s3;
	logic [57:0]        acc;

	// square and linear products
	assign tt = t_s1 * t_s1;
	assign bt = $signed({1'b0, lj2s_pkg::CURVE_B}) * t_s1;

	// split the square so each product stays narrow
	always_ff @(posedge clk) begin
		if (en) begin
			tt_s2 <= tt[37:0];
			bt_s2 <= bt;
			ph_s3 <= lj2s_pkg::CURVE_A * tt_s2[37:19];
			pl_s3 <= lj2s_pkg::CURVE_A * tt_s2[18:0];
			bt_s3 <= bt_s2;
			c_s4  <= $signed(acc[57:32]);
		end
	end

	// sum at 40 fraction bits, half added for rounding
	assign acc = 58'({ph_s3, 19'b0}) + 58'(pl_s3) + (58'(bt_s3) << 8) + lj2s_pkg::CURVE_K;

endmodule

`default_nettype wire

### src/lj2s_duty.sv
// ----------------------------------------------------------------------------
// lj2s_duty
// Two-stage scale of a clamped angle: floor(d * 409 / 46080).
// ----------------------------------------------------------------------------
`default_nettype none

module lj2s_duty (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] d_s5,
	output logic [8:0]       q_s7
);

	logic [24:0] x;
	logic [14:0] y_s6;
	logic [37:0] p;

	// scale by 409 and drop the power-of-two part of 46080
	assign x = d_s5 * lj2s_pkg::DUTY_SPAN;
	// divide by 45 through the reciprocal, exact for y below 2^15
	assign p = y_s6 * lj2s_pkg::RECIP45;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s6 <= x[24:10];
			q_s7 <= p[36:28];
		end
	end

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// Leg joint to servo PWM mapper testbench
// Sends leg joint items through valid/ready channels under several idle and
// stall mixes and curve bias settings. Every servo result is checked field by
// field against a bit-exact predictor of the hip, thigh and shank duty math.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0]  lch;
		logic        board;
		logic [2:0]  bch;
		logic [12:0] on_cnt;
		logic [12:0] off_cnt;
		logic        last;
	} servo_res_t;

	// Predicts servo results for each accepted leg transaction
	class servo_scoreboard;
		servo_res_t want_q[$];
		longint     bias;
		int         errors;

		function new();
			bias = 0;
			errors = 0;
		endfunction

		task report(input string what, input longint got, input longint exp_v);
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, exp_v);
			errors++;
		endtask

		function longint fit_deg(input longint a);
			if (a > 46080) return 46080;
			if (a < 0) return 0;
			return a;
		endfunction

		function longint bend(input longint t);
			longint acc;
			acc = 64'sd111552 * t * t + 64'sd7405463 * t * 256 + 64'sd92778004 * 65536;
			return (acc + (64'sd1 <<< 31)) >>> 32;
		endfunction

		function servo_res_t make_res(input int lch, input int brd, input int bch,
				input longint deg, input bit last);
			servo_res_t r;
			longint duty;
			if (deg <= 0) duty = 102;
			else duty = 102 + (deg * 409) / 46080;
			if (duty > 511) duty = 511;
			r.lch = lch[3:0];
			r.board = brd[0];
			r.bch = bch[2:0];
			r.on_cnt = 13'd0;
			r.off_cnt = duty[12:0];
			r.last = last;
			return r;
		endfunction

		// push hip, thigh and shank expectations for one leg
		function void note_leg(input lj2s_pkg::item_t it);
			bit left, rear;
			int brd, bbase, lbase;
			longint hip, thigh, shank, c;
			left = (it.leg == 2'd0 || it.leg == 2'd3);
			rear = (it.leg == 2'd2 || it.leg == 2'd3);
			brd = left ? 0 : 1;
			bbase = rear ? 3 : 0;
			lbase = brd * 6 + bbase;
			hip = fit_deg(longint'(it.rest_hip) + longint'(it.hip_offset));
			if (it.ik_mode) begin
				c = bend(longint'(it.shank_angle) + bias + longint'(it.shank_trim));
				if (left) begin
					thigh = longint'(it.rest_thigh) + 23040 - longint'(it.thigh_angle);
					shank = fit_deg(longint'(it.rest_shank) - 23040 + c
						+ longint'(it.crawl_comp));
				end else begin
					thigh = longint'(it.rest_thigh) - 23040 + longint'(it.thigh_angle);
					shank = fit_deg(longint'(it.rest_shank) + 23040 - c
						+ longint'(it.crawl_comp));
				end
			end else begin
				thigh = longint'(it.rest_thigh);
				shank = longint'(it.rest_shank);
			end
			want_q.push_back(make_res(lbase, brd, bbase, hip, 0));
			want_q.push_back(make_res(lbase + 1, brd, bbase + 1, thigh, 0));
			want_q.push_back(make_res(lbase + 2, brd, bbase + 2, shank, 1));
		endfunction

		task check_res(input servo_res_t got);
			servo_res_t w;
			if (want_q.size() == 0) begin
				report("unexpected result", got.lch, -1);
				return;
			end
			w = want_q.pop_front();
			if (got.lch !== w.lch) report("logical_channel", got.lch, w.lch);
			if (got.board !== w.board) report("board_select", got.board, w.board);
			if (got.bch !== w.bch) report("board_channel", got.bch, w.bch);
			if (got.on_cnt !== w.on_cnt) report("on_count", got.on_cnt, w.on_cnt);
			if (got.off_cnt !== w.off_cnt) report("off_count", got.off_cnt, w.off_cnt);
			if (got.last !== w.last) report("last_of_leg", got.last, w.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	lj2s_in_if  joint();
	lj2s_cfg_if cfg();
	lj2s_out_if servo();

	leg_joint_to_servo_pwm u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.joint (joint),
		.cfg   (cfg),
		.servo (servo)
	);

	servo_scoreboard sb = new();
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  quiet_cycles;

	localparam int WATCHDOG_LIMIT = 5000;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// sample transactions and guard against a hang
	always @(posedge clk) begin
		servo_res_t r;
		if (arst_n) begin
			if (joint.valid && joint.ready || servo.valid && servo.ready
					|| cfg.valid && cfg.ready)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (cfg.valid && cfg.ready)
				sb.bias = longint'(cfg.curve_bias);
			if (joint.valid && joint.ready)
				sb.note_leg(lj2s_pkg::item_t'{joint.leg, joint.ik_mode, joint.rest_hip,
					joint.rest_thigh, joint.rest_shank, joint.hip_offset,
					joint.thigh_angle, joint.shank_angle, joint.shank_trim,
					joint.crawl_comp});
			if (servo.valid && servo.ready) begin
				r.lch = servo.logical_channel;
				r.board = servo.board_select;
				r.bch = servo.board_channel;
				r.on_cnt = servo.on_count;
				r.off_cnt = servo.off_count;
				r.last = servo.last_of_leg;
				sb.check_res(r);
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		servo.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				servo.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			servo.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task send_leg(input lj2s_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			joint.valid <= 1'b0;
			@(negedge clk);
		end
		joint.valid <= 1'b1;
		joint.leg <= it.leg;
		joint.ik_mode <= it.ik_mode;
		joint.rest_hip <= it.rest_hip;
		joint.rest_thigh <= it.rest_thigh;
		joint.rest_shank <= it.rest_shank;
		joint.hip_offset <= it.hip_offset;
		joint.thigh_angle <= it.thigh_angle;
		joint.shank_angle <= it.shank_angle;
		joint.shank_trim <= it.shank_trim;
		joint.crawl_comp <= it.crawl_comp;
		@(posedge clk);
		while (!joint.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drain, let the pipeline settle, then write the bias register
	task write_bias(input logic signed [lj2s_pkg::ANG_W-1:0] v);
		joint.valid <= 1'b0;
		while (sb.want_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.curve_bias <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function logic signed [lj2s_pkg::ANG_W-1:0] pick_angle();
		if ($urandom_range(3) == 0) return 18'($urandom);
		return 18'($signed($urandom_range(0, 92160)) - 32'sd23040);
	endfunction

	function lj2s_pkg::item_t pick_leg();
		lj2s_pkg::item_t it;
		it.leg = 2'($urandom_range(3));
		it.ik_mode = ($urandom_range(9) != 0);
		it.rest_hip = pick_angle();
		it.rest_thigh = pick_angle();
		it.rest_shank = pick_angle();
		it.hip_offset = pick_angle();
		it.thigh_angle = pick_angle();
		it.shank_angle = ($urandom_range(3) == 0) ? 18'($urandom)
			: 18'($signed($urandom_range(0, 46080)) - 32'sd23040);
		it.shank_trim = ($urandom_range(3) == 0) ? 18'($urandom)
			: 18'($signed($urandom_range(0, 2560)) - 32'sd1280);
		it.crawl_comp = pick_angle();
		return it;
	endfunction

	initial begin
		lj2s_pkg::item_t it;
		logic signed [lj2s_pkg::ANG_W-1:0] bias_set [5];
		int idle_set [5];
		int stall_set [5];
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		joint.valid = 1'b0;
		joint.leg = '0;
		joint.ik_mode = 1'b0;
		joint.rest_hip = '0;
		joint.rest_thigh = '0;
		joint.rest_shank = '0;
		joint.hip_offset = '0;
		joint.thigh_angle = '0;
		joint.shank_angle = '0;
		joint.shank_trim = '0;
		joint.crawl_comp = '0;
		cfg.valid = 1'b0;
		cfg.curve_bias = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every leg in both modes, field extremes, clamp edges
		for (int l = 0; l < 4; l++) begin
			for (int m = 0; m < 2; m++) begin
				it = '{l[1:0], m[0], 18'sd23040, 18'sd23040, 18'sd23040, 18'sd2560,
					18'sd5120, 18'sd10240, 18'sd256, 18'sd512};
				send_leg(it);
			end
		end
		it = '{2'd0, 1'b1, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF,
			18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF};
		send_leg(it);
		it = '{2'd1, 1'b1, 18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000,
			18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000};
		send_leg(it);
		it = '{2'd3, 1'b0, 18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF,
			18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF};
		send_leg(it);
		// hip sum exactly 180 and exactly 0; stance thigh just below duty max
		it = '{2'd2, 1'b0, 18'sd46079, 18'sd45967, 18'sd1, 18'sd1, 18'sd0, 18'sd0,
			18'sd0, 18'sd0};
		send_leg(it);
		it = '{2'd0, 1'b0, 18'sd100, 18'sh1FFFF, 18'sd0, -18'sd100, 18'sd0, 18'sd0,
			18'sd0, 18'sd0};
		send_leg(it);
		it = '{2'd1, 1'b1, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0,
			18'sd0};
		send_leg(it);
		it = '{2'd2, 1'b1, 18'sd0, 18'sd0, 18'sd0, 18'sd0, -18'sd23040,
			-18'sd17920, 18'sd0, 18'sd0};
		send_leg(it);

		// random phases: bias setting, sender idle and receiver stall mix
		bias_set = '{18'sh1FFFF, 18'sh20000, 18'sd0, 18'sd1280, -18'sd2560};
		idle_set = '{0, 74, 0, 28, 0};
		stall_set = '{0, 0, 74, 28, 0};
		for (int p = 0; p < 5; p++) begin
			write_bias(p == 4 ? 18'($urandom) : bias_set[p]);
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			if (p == 4) hold_req = 1'b1;
			for (int n = 0; n < 48; n++) begin
				// mix long full-speed runs with bursts of gaps
				if (p == 0 && n == 24) send_idle_pct = 50;
				send_leg(pick_leg());
			end
		end
		joint.valid <= 1'b0;
		recv_stall_pct = 0;

		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/lj2s_pkg.sv
src/lj2s_if.sv
src/lj2s_curve.sv
src/lj2s_duty.sv
src/leg_joint_to_servo_pwm.sv
bench/tb.sv
